// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the character stream tokenizer
// Request and token payload layouts, token kinds, keyword table, scan modes.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int CHAR_W            = 8;
  localparam int KIND_W            = 3;
  localparam int LEN_FIELD_W       = 8;
  localparam int POS_FIELD_W       = 20;
  localparam int MAX_RESULTS       = 3;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);
  localparam int NUM_KW            = 3;
  localparam int DEF_MAX_TOKEN_LEN = 255;
  localparam int DEF_POSITION_BITS = 20;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NUM     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OP      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

  // special bytes
  localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_NUM   = 3'b010,
    MODE_IDENT = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              end_of_source;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]      token_kind;
    logic [LEN_FIELD_W-1:0] token_length;
    logic [CHAR_W-1:0]      operator_char;
    logic [POS_FIELD_W-1:0] line_number;
    logic [POS_FIELD_W-1:0] column_number;
    logic                   last_result;
  } out_t;

  // all tokens produced by one request, first token in res[0]
  typedef struct packed {
    out_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]       cnt;
  } res_bundle_t;

  function automatic logic is_op(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  // keyword lengths: if, else, return
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      2'd0:    len = 3'd2;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [CHAR_W-1:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (p)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/cst_scan.sv =====
// ----------------------------------------------------------------------------
// cst_scan: scanner state and per-byte token decode
// Holds mode, run length, keyword candidates and position counters; builds
// the up to three tokens caused by one request.
// ----------------------------------------------------------------------------
module cst_scan #(
  parameter int MAX_TOKEN_LEN = cst_pkg::DEF_MAX_TOKEN_LEN,
  parameter int POSITION_BITS = cst_pkg::DEF_POSITION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  cst_pkg::in_t         in_data,
  output cst_pkg::res_bundle_t res
);

  localparam int RunW   = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PosW   = POSITION_BITS;
  localparam int FieldW = cst_pkg::POS_FIELD_W;
  localparam int LenW   = cst_pkg::LEN_FIELD_W;
  localparam int CntW   = cst_pkg::CNT_W;
  localparam logic [RunW-1:0] RunMax = RunW'(MAX_TOKEN_LEN);
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] PosOne = PosW'(1);

  cst_pkg::scan_mode_t mode_r, mode_nxt;
  logic [RunW-1:0]     run_r, run_nxt;
  logic [2:0]          cand_r, cand_nxt;
  logic [PosW-1:0]     line_r, line_nxt;
  logic [PosW-1:0]     col_r, col_nxt;

  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic logic [2:0] ext_cand(input logic [2:0] cand, input logic [RunW-1:0] p,
                                          input logic [7:0] c);
    logic [2:0] keep;
    for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
      keep[k] = (p < RunW'(cst_pkg::kw_len(2'(k)))) &&
                (cst_pkg::kw_char(2'(k), p[2:0]) == c);
    end
    return cand & keep;
  endfunction

  function automatic logic [cst_pkg::KIND_W-1:0] run_kind(input cst_pkg::scan_mode_t m,
                                                          input logic [2:0] cand,
                                                          input logic [RunW-1:0] p);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
      if (cand[k] && (p == RunW'(cst_pkg::kw_len(2'(k))))) hit = 1'b1;
    end
    if (m == cst_pkg::MODE_NUM) return cst_pkg::KIND_NUM;
    return hit ? cst_pkg::KIND_KEYWORD : cst_pkg::KIND_IDENT;
  endfunction

  function automatic logic [LenW-1:0] len_field(input logic [RunW-1:0] p);
    return (32'(p) > 32'((1 << LenW) - 1)) ? '1 : LenW'(p);
  endfunction

  function automatic cst_pkg::out_t mk_tok(input logic [cst_pkg::KIND_W-1:0] kind,
                                           input logic [LenW-1:0] len,
                                           input logic [7:0] op,
                                           input logic [PosW-1:0] ln,
                                           input logic [PosW-1:0] cl);
    cst_pkg::out_t t;
    t.token_kind    = kind;
    t.token_length  = len;
    t.operator_char = op;
    t.line_number   = FieldW'(ln);
    t.column_number = FieldW'(cl);
    t.last_result   = 1'b0;
    return t;
  endfunction

  logic [7:0]    c;
  logic          v, eos;
  logic          is_dig, is_let, is_us, is_semi, is_opc;
  logic          grow_run, starts;
  logic [RunW-1:0] base_run;
  logic [2:0]    base_cand;
  cst_pkg::scan_mode_t mode1;
  logic [RunW-1:0] run1;
  logic [2:0]    cand1;
  logic [PosW-1:0] line1, col1;
  cst_pkg::out_t tok [4];
  logic [3:0]    emit;
  cst_pkg::out_t lst [4];
  logic [2:0]    n;

  always_comb begin
    c       = in_data.char_code;
    v       = in_data.char_valid;
    eos     = in_data.end_of_source;
    is_dig  = (c >= "0") && (c <= "9");
    is_let  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    is_us   = (c == cst_pkg::CH_UNDERSCORE);
    is_semi = (c == cst_pkg::CH_SEMI);
    is_opc  = cst_pkg::is_op(c);

    unique case (mode_r)
      cst_pkg::MODE_NUM:   grow_run = v && is_dig;
      cst_pkg::MODE_IDENT: grow_run = v && (is_dig || is_let || is_us);
      default:             grow_run = 1'b0;
    endcase
    starts = v && !grow_run && (is_dig || is_let);

    base_run  = grow_run ? run_r : '0;
    base_cand = grow_run ? cand_r : 3'b111;

    mode1 = mode_r;
    run1  = run_r;
    cand1 = cand_r;
    line1 = line_r;
    col1  = col_r;
    if (v) begin
      if (grow_run || starts) begin
        run1  = (base_run < RunMax) ? base_run + RunW'(1) : base_run;
        cand1 = ext_cand(base_cand, base_run, c);
        mode1 = grow_run ? mode_r : (is_dig ? cst_pkg::MODE_NUM : cst_pkg::MODE_IDENT);
      end else begin
        run1  = '0;
        cand1 = 3'b111;
        mode1 = cst_pkg::MODE_IDLE;
      end
      col1  = is_semi ? '0 : sat_inc(col_r);
      line1 = is_semi ? sat_inc(line_r) : line_r;
    end

    // candidates in emission order: closed run, operator, run closed by end, end
    tok[0]  = mk_tok(run_kind(mode_r, cand_r, run_r), len_field(run_r), 8'h00, line_r, col_r);
    emit[0] = v && (mode_r != cst_pkg::MODE_IDLE) && !grow_run;
    tok[1]  = mk_tok(cst_pkg::KIND_OP, LenW'(1), c, line_r, col_r);
    emit[1] = v && !grow_run && is_opc;
    tok[2]  = mk_tok(run_kind(mode1, cand1, run1), len_field(run1), 8'h00, line1, col1);
    emit[2] = eos && (mode1 != cst_pkg::MODE_IDLE);
    tok[3]  = mk_tok(cst_pkg::KIND_END, '0, 8'h00, line1, col1);
    emit[3] = eos;

    n = 3'd0;
    for (int i = 0; i < 4; i++) lst[i] = tok[3];
    for (int i = 0; i < 4; i++) begin
      if (emit[i]) begin
        lst[n[1:0]] = tok[i];
        n = n + 3'd1;
      end
    end
    for (int j = 0; j < cst_pkg::MAX_RESULTS; j++) begin
      res.res[j]             = lst[j];
      res.res[j].last_result = (3'(j) == (n - 3'd1));
    end
    res.cnt = CntW'(n);

    if (eos) begin
      mode_nxt = cst_pkg::MODE_IDLE;
      run_nxt  = '0;
      cand_nxt = 3'b111;
      line_nxt = PosOne;
      col_nxt  = PosOne;
    end else begin
      mode_nxt = mode1;
      run_nxt  = run1;
      cand_nxt = cand1;
      line_nxt = line1;
      col_nxt  = col1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cst_pkg::MODE_IDLE;
      run_r  <= '0;
      cand_r <= 3'b111;
      line_r <= PosOne;
      col_r  <= PosOne;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      cand_r <= cand_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == cst_pkg::MODE_IDLE) == (run_r == '0))
    else $error("run length out of step with scan mode");

  a_idle_all_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == cst_pkg::MODE_IDLE) |-> (cand_r == 3'b111))
    else $error("keyword candidates not restored while idle");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.end_of_source |=>
      (mode_r == cst_pkg::MODE_IDLE) && (line_r == PosOne) && (col_r == PosOne))
    else $error("scanner state not restarted after end of source");
`endif

endmodule

// ===== hw/rtl/cst_outq.sv =====
// ----------------------------------------------------------------------------
// cst_outq: token output register queue
// Loads all tokens of one request at once and hands them out in order.
// ----------------------------------------------------------------------------
module cst_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  cst_pkg::res_bundle_t load_res,
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cst_pkg::out_t        out_data
);

  localparam int Depth = cst_pkg::MAX_RESULTS;
  localparam int CntW  = cst_pkg::CNT_W;

  cst_pkg::out_t   q_r [Depth];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign out_valid  = (cnt_r != '0);
  assign out_data   = q_r[0];
  assign pop        = out_valid && out_ready;
  // room once the queue is empty or its final token leaves this cycle
  assign load_ready = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_ready);

  always_comb begin
    if (in_fire)  cnt_nxt = load_res.cnt;
    else if (pop) cnt_nxt = cnt_r - CntW'(1);
    else          cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < Depth; i++) q_r[i] <= load_res.res[i];
    end else if (pop) begin
      for (int i = 0; i < Depth - 1; i++) q_r[i] <= q_r[i+1];
    end
  end

`ifndef SYNTHESIS
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> cnt_r == $past(load_res.cnt))
    else $error("queue count differs from loaded token count");

  a_final_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r == CntW'(1)) |-> q_r[0].last_result)
    else $error("final queued token lacks last_result");

  a_marked_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && q_r[0].last_result |-> cnt_r == CntW'(1))
    else $error("last_result token is not the final queued token");
`endif

endmodule

// ===== hw/rtl/char_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_stream_tokenizer: byte-serial lexical tokenizer
// Turns a stream of source bytes into identifier, number, keyword, operator
// and end tokens, each tagged with its line and column.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | in        | in_valid / in_ready    | in_data  (cst_pkg::in_t)
//  out_    | out       | out_valid / out_ready  | out_data (cst_pkg::out_t)
//
//  - One request per cycle while out_ready is high and no request yields
//    more than one token; k tokens (k <= 3) stall input until the last is taken.
//  - The 3-entry output queue sets the rate: in_ready is high when the queue
//    is empty, or when its final token is being taken in the same cycle.
//  - Decode is combinational logic between the request port and the queue.
//  - Reset is synchronous, active low: scanner idle, line and column one.
//  - out_valid does not depend on in_valid; a stalled output holds its token.
//
module char_stream_tokenizer #(
  parameter int MAX_TOKEN_LEN = cst_pkg::DEF_MAX_TOKEN_LEN,
  parameter int POSITION_BITS = cst_pkg::DEF_POSITION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cst_pkg::out_t out_data
);

  // all tokens of the request being accepted, already in order and marked
  cst_pkg::res_bundle_t res;
  logic                 in_fire;

  assign in_fire = in_valid && in_ready;

  // scanner state advances only on an accepted request
  cst_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .res     (res)
  );

  // output queue doubles as the result register; its fill level gates input
  cst_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .load_res   (res),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
